>>> src/bcp_pkg.sv
package bcp_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;
    localparam int GUARD_BITS  = 4;
    localparam int WIDE_BITS   = COORD_BITS + GUARD_BITS;
    localparam int DIFF_BITS   = WIDE_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + T_BITS;

    localparam logic KIND_QUAD  = 1'b0;
    localparam logic KIND_CUBIC = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [T_BITS-1:0]     tval_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        logic   kind;
        tval_t  t_param;
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p3_x;
        coord_t p3_y;
    } bcp_req_t;

    typedef struct packed {
        coord_t curve_x;
        coord_t curve_y;
    } bcp_pt_t;

endpackage

>>> src/bezier_curve_point.sv
// Throughput: one request per cycle, unless a low pt_ready stalls the output.
// Each of the three de Casteljau levels takes three stages (difference,
// multiply-accumulate, add), plus one stage for final rounding and
// saturation, which is also the output register.
// Each stage holds its item only while stalled, so bubbles are squeezed out.
// Reset (rst_n low, asynchronous) clears the valid bits only.
module bezier_curve_point (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bcp_pkg::bcp_req_t req,
    output logic              pt_valid,
    input  logic              pt_ready,
    output bcp_pkg::bcp_pt_t  pt
);
    import bcp_pkg::*;

    localparam int N_STAGES = 10;
    localparam int NAX      = 2;

    localparam tval_t T_ONE  = tval_t'(1 << T_FRAC_BITS);
    localparam prod_t HALF_T = prod_t'(1 << (T_FRAC_BITS - 1));
    localparam logic signed [WIDE_BITS:0] HALF_G = (WIDE_BITS+1)'(1 << (GUARD_BITS - 1));
    localparam logic signed [WIDE_BITS:0] C_MAX  = (WIDE_BITS+1)'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [WIDE_BITS:0] C_MIN  = -(WIDE_BITS+1)'(1 << (COORD_BITS - 1));

    function automatic diff_t sub_w(wide_t b, wide_t a);
        return diff_t'(b) - diff_t'(a);
    endfunction

    function automatic prod_t mac_t(diff_t d, tval_t t);
        logic signed [PROD_BITS:0] full;
        full = d * $signed({1'b0, t});
        return prod_t'(full[PROD_BITS-1:0]) + HALF_T;
    endfunction

    function automatic wide_t add_w(wide_t a, prod_t m);
        prod_t sh;
        sh = m >>> T_FRAC_BITS;
        return a + wide_t'(sh[WIDE_BITS-1:0]);
    endfunction

    function automatic wide_t widen(coord_t c);
        return wide_t'({c, {GUARD_BITS{1'b0}}});
    endfunction

    logic [N_STAGES-1:0] v_reg;
    logic [N_STAGES-1:0] en;

    always_comb
    begin
        en[N_STAGES-1] = !v_reg[N_STAGES-1] || pt_ready;
        for (int i = N_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign req_ready = en[0];
    assign pt_valid  = v_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int i = 1; i < N_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // request unpack
    coord_t pin [NAX][4];
    tval_t  t_sat;

    always_comb
    begin
        pin[0][0] = req.p0_x;
        pin[1][0] = req.p0_y;
        pin[0][1] = req.p1_x;
        pin[1][1] = req.p1_y;
        pin[0][2] = req.p2_x;
        pin[1][2] = req.p2_y;
        pin[0][3] = req.p3_x;
        pin[1][3] = req.p3_y;
        t_sat = (req.t_param[T_BITS-1] && (|req.t_param[T_FRAC_BITS-1:0])) ?
                T_ONE : req.t_param;
    end

    // level 1: P0..P3 -> a, b, c
    wide_t base0_reg [NAX][3];
    diff_t dif0_reg  [NAX][3];
    wide_t base1_reg [NAX][3];
    prod_t mul1_reg  [NAX][3];
    wide_t pt2_reg   [NAX][3];
    // level 2: a, b, c -> d, e
    wide_t base3_reg [NAX][2];
    diff_t dif3_reg  [NAX][2];
    wide_t base4_reg [NAX][2];
    prod_t mul4_reg  [NAX][2];
    wide_t pt5_reg   [NAX][2];
    // level 3: d, e -> curve point
    wide_t base6_reg [NAX];
    diff_t dif6_reg  [NAX];
    wide_t base7_reg [NAX];
    prod_t mul7_reg  [NAX];
    wide_t pt8_reg   [NAX];

    tval_t t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic  kind0_reg, kind1_reg, kind2_reg, kind3_reg, kind4_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    base0_reg[ax][k] <= widen(pin[ax][k]);
                    dif0_reg[ax][k]  <= sub_w(widen(pin[ax][k+1]), widen(pin[ax][k]));
                end
            end
            t0_reg    <= t_sat;
            kind0_reg <= req.kind;
        end
        if (en[1])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    base1_reg[ax][k] <= base0_reg[ax][k];
                    mul1_reg[ax][k]  <= mac_t(dif0_reg[ax][k], t0_reg);
                end
            end
            t1_reg    <= t0_reg;
            kind1_reg <= kind0_reg;
        end
        if (en[2])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pt2_reg[ax][k] <= add_w(base1_reg[ax][k], mul1_reg[ax][k]);
                end
            end
            t2_reg    <= t1_reg;
            kind2_reg <= kind1_reg;
        end
        if (en[3])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    base3_reg[ax][k] <= pt2_reg[ax][k];
                    dif3_reg[ax][k]  <= sub_w(pt2_reg[ax][k+1], pt2_reg[ax][k]);
                end
            end
            t3_reg    <= t2_reg;
            kind3_reg <= kind2_reg;
        end
        if (en[4])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    base4_reg[ax][k] <= base3_reg[ax][k];
                    mul4_reg[ax][k]  <= mac_t(dif3_reg[ax][k], t3_reg);
                end
            end
            t4_reg    <= t3_reg;
            kind4_reg <= kind3_reg;
        end
        if (en[5])
        begin
            // quadratic: d is the point; e = d makes the last lerp a pass-through
            for (int ax = 0; ax < NAX; ax++)
            begin
                pt5_reg[ax][0] <= add_w(base4_reg[ax][0], mul4_reg[ax][0]);
                pt5_reg[ax][1] <= (kind4_reg == KIND_CUBIC) ?
                                  add_w(base4_reg[ax][1], mul4_reg[ax][1]) :
                                  add_w(base4_reg[ax][0], mul4_reg[ax][0]);
            end
            t5_reg <= t4_reg;
        end
        if (en[6])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                base6_reg[ax] <= pt5_reg[ax][0];
                dif6_reg[ax]  <= sub_w(pt5_reg[ax][1], pt5_reg[ax][0]);
            end
            t6_reg <= t5_reg;
        end
        if (en[7])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                base7_reg[ax] <= base6_reg[ax];
                mul7_reg[ax]  <= mac_t(dif6_reg[ax], t6_reg);
            end
        end
        if (en[8])
        begin
            for (int ax = 0; ax < NAX; ax++)
            begin
                pt8_reg[ax] <= add_w(base7_reg[ax], mul7_reg[ax]);
            end
        end
    end

    // final round to Q16.8 and saturate
    logic signed [WIDE_BITS:0] rnd [NAX];
    logic                      sat_hi [NAX];
    logic                      sat_lo [NAX];
    coord_t                    fin [NAX];
    bcp_pt_t                   pt_next;
    bcp_pt_t                   pt_reg;

    always_comb
    begin
        for (int ax = 0; ax < NAX; ax++)
        begin
            rnd[ax]    = ((WIDE_BITS+1)'(pt8_reg[ax]) + HALF_G) >>> GUARD_BITS;
            sat_hi[ax] = rnd[ax] > C_MAX;
            sat_lo[ax] = rnd[ax] < C_MIN;
            if (sat_hi[ax])
            begin
                fin[ax] = coord_t'(C_MAX);
            end
            else if (sat_lo[ax])
            begin
                fin[ax] = coord_t'(C_MIN);
            end
            else
            begin
                fin[ax] = coord_t'(rnd[ax]);
            end
        end
        pt_next.curve_x = fin[0];
        pt_next.curve_y = fin[1];
    end

    always_ff @(posedge clk)
    begin
        if (en[N_STAGES-1])
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt = pt_reg;

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pt_valid |-> req_ready)
        else $error("request stalled with empty output stage");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> v_reg[0])
        else $error("accepted request not in first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !en[0]) |=> v_reg[0])
        else $error("stalled first stage lost its item");

    a_occupancy_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(v_reg) <= $past($countones(v_reg)) + 1) &&
        ($countones(v_reg) + 1 >= $past($countones(v_reg))))
        else $error("pipeline occupancy jumped");

    a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N_STAGES-2] |-> !(sat_hi[0] || sat_lo[0] || sat_hi[1] || sat_lo[1]))
        else $error("curve point left the control hull");

endmodule

>>> test/tb_bezier_curve_point.sv
`timescale 1ns / 100ps

module tb_bezier_curve_point;
    import bcp_pkg::*;

    localparam int     GAP_MAX      = 5;
    localparam int     RAND_ITEMS   = 1750;
    localparam int     STALL_LIMIT  = 1000;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     MAX_REPORTS  = 10;
    localparam coord_t C_MAX        = 24'h7FFFFF;
    localparam coord_t C_MIN        = 24'h800000;
    localparam tval_t  T_ONE        = tval_t'(1) << T_FRAC_BITS;

    typedef struct {
        bcp_req_t r;
        bit       typed;
        bcp_pt_t  pt;
    } vec_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    bcp_req_t req;
    logic     pt_valid;
    logic     pt_ready;
    bcp_pt_t  pt;

    bcp_pt_t  point_q[$];
    vec_row_t vec_tbl[$];
    int       mismatches = 0;
    int       stall_cnt = 0;
    int       rx_hold = 0;
    bit       burst = 1'b0;

    bezier_curve_point uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt        (pt)
    );

    always #5 clk = ~clk;

    // round to nearest, ties toward plus infinity
    function automatic longint round_off(longint x, int sh);
        return (x + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint lerp(longint a, longint b, longint t);
        return a + round_off((b - a) * t, T_FRAC_BITS);
    endfunction

    function automatic coord_t axis_point(logic kind, longint t,
                                          coord_t c0, coord_t c1, coord_t c2, coord_t c3);
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        longint ab;
        longint bc;
        longint cd;
        longint r;
        w0 = longint'(c0) * (longint'(1) << GUARD_BITS);
        w1 = longint'(c1) * (longint'(1) << GUARD_BITS);
        w2 = longint'(c2) * (longint'(1) << GUARD_BITS);
        w3 = longint'(c3) * (longint'(1) << GUARD_BITS);
        ab = lerp(w0, w1, t);
        bc = lerp(w1, w2, t);
        if (kind == KIND_CUBIC)
        begin
            cd = lerp(w2, w3, t);
            ab = lerp(ab, bc, t);
            bc = lerp(bc, cd, t);
        end
        r = round_off(lerp(ab, bc, t), GUARD_BITS);
        if (r > longint'(C_MAX))
            r = longint'(C_MAX);
        if (r < longint'(C_MIN))
            r = longint'(C_MIN);
        return coord_t'(r);
    endfunction

    function automatic bcp_pt_t bezier_point(bcp_req_t r);
        longint  t;
        bcp_pt_t p;
        t = longint'(r.t_param);
        if (t > longint'(T_ONE))
            t = longint'(T_ONE);
        p.curve_x = axis_point(r.kind, t, r.p0_x, r.p1_x, r.p2_x, r.p3_x);
        p.curve_y = axis_point(r.kind, t, r.p0_y, r.p1_y, r.p2_y, r.p3_y);
        return p;
    endfunction

    function automatic bcp_req_t rand_req();
        bcp_req_t r;
        coord_t   c[8];
        coord_t   base;
        int       style;
        int       pick;
        style = $urandom_range(0, 9);
        base  = coord_t'($urandom);
        for (int k = 0; k < 8; k++)
        begin
            if (style < 5)
                c[k] = coord_t'($urandom);
            else if (style < 8)
                c[k] = base + coord_t'($urandom_range(0, 1023)) - 24'sd512;
            else
            begin
                case ($urandom_range(0, 4))
                    0:       c[k] = C_MAX;
                    1:       c[k] = C_MIN;
                    2:       c[k] = '0;
                    3:       c[k] = '1;
                    default: c[k] = coord_t'($urandom);
                endcase
            end
        end
        r.kind = ($urandom_range(0, 1) == 0) ? KIND_QUAD : KIND_CUBIC;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.t_param = ($urandom_range(0, 1) == 0) ? tval_t'(0) : T_ONE;
        else if (pick < 3)
            r.t_param = tval_t'($urandom);
        else
            r.t_param = tval_t'($urandom_range(0, int'(T_ONE)));
        r.p0_x = c[0];
        r.p0_y = c[1];
        r.p1_x = c[2];
        r.p1_y = c[3];
        r.p2_x = c[4];
        r.p2_y = c[5];
        r.p3_x = c[6];
        r.p3_y = c[7];
        return r;
    endfunction

    task automatic add_row(logic kind, tval_t t,
                           coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                           coord_t x2, coord_t y2, coord_t x3, coord_t y3,
                           bit typed, coord_t ex, coord_t ey);
        vec_row_t row;
        row.r.kind    = kind;
        row.r.t_param = t;
        row.r.p0_x    = x0;
        row.r.p0_y    = y0;
        row.r.p1_x    = x1;
        row.r.p1_y    = y1;
        row.r.p2_x    = x2;
        row.r.p2_y    = y2;
        row.r.p3_x    = x3;
        row.r.p3_y    = y3;
        row.typed     = typed;
        row.pt.curve_x = ex;
        row.pt.curve_y = ey;
        vec_tbl.push_back(row);
    endtask

    task automatic send_req(bcp_req_t r, bit typed, bcp_pt_t hand);
        int gap;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_ready !== 1'b1);
        point_q.push_back(typed ? hand : bezier_point(r));
    endtask

    task automatic drain_points();
        req_valid <= 1'b0;
        do @(posedge clk); while (point_q.size() != 0);
    endtask

    // point receiver
    initial
    begin
        int stall;
        pt_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall   = rx_hold + (burst ? 0 : $urandom_range(0, GAP_MAX));
            rx_hold = 0;
            if (stall > 0)
            begin
                pt_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pt_ready <= 1'b1;
            do @(posedge clk); while (pt_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        bcp_pt_t want;
        if (rst_n === 1'b1 && pt_valid === 1'b1 && pt_ready === 1'b1)
        begin
            if (point_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point x=%0d y=%0d", pt.curve_x, pt.curve_y);
            end
            else
            begin
                want = point_q.pop_front();
                if (pt.curve_x !== want.curve_x || pt.curve_y !== want.curve_y)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("point mismatch: want x=%0d y=%0d, got x=%0d y=%0d",
                                 want.curve_x, want.curve_y, pt.curve_x, pt.curve_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_ready === 1'b1) ||
            (pt_valid === 1'b1 && pt_ready === 1'b1))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // ends of t give the end points; t above one saturates; then extreme control points
        add_row(KIND_QUAD, '0, 1000, -2000, C_MAX, C_MIN, -5, 7, 0, 0, 1, 1000, -2000);
        add_row(KIND_QUAD, T_ONE, 1000, -2000, C_MAX, C_MIN, -5, 7, 0, 0, 1, -5, 7);
        add_row(KIND_QUAD, T_ONE + tval_t'(1), 1000, -2000, C_MAX, C_MIN, -5, 7, 0, 0, 1, -5, 7);
        add_row(KIND_CUBIC, '0, -300, 450, C_MIN, C_MAX, C_MAX, C_MIN, 12345, -54321,
                1, -300, 450);
        add_row(KIND_CUBIC, T_ONE, -300, 450, C_MIN, C_MAX, C_MAX, C_MIN, 12345, -54321,
                1, 12345, -54321);
        add_row(KIND_CUBIC, '1, -300, 450, C_MIN, C_MAX, C_MAX, C_MIN, 12345, -54321,
                1, 12345, -54321);
        add_row(KIND_CUBIC, 17'h08000, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                1, C_MAX, C_MAX);
        add_row(KIND_QUAD, 17'h01234, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                1, C_MIN, C_MIN);
        add_row(KIND_CUBIC, '0, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                1, C_MAX, C_MAX);
        add_row(KIND_CUBIC, 17'h08000, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                0, 0, 0);
        add_row(KIND_QUAD, 17'h08000, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0, 0);
        // quadratic ignores the fourth point; then t next to zero and next to one
        add_row(KIND_QUAD, 17'h04000, 100, 200, -300, 400, 500, -600, C_MAX, C_MAX, 0, 0, 0);
        add_row(KIND_QUAD, 17'h04000, 100, 200, -300, 400, 500, -600, C_MIN, C_MIN, 0, 0, 0);
        add_row(KIND_CUBIC, 17'h00001, 7, -7, C_MAX, C_MIN, C_MIN, C_MAX, -9, 9, 0, 0, 0);
        add_row(KIND_CUBIC, 17'h0FFFF, 7, -7, C_MAX, C_MIN, C_MIN, C_MAX, -9, 9, 0, 0, 0);
        // rounding ties
        add_row(KIND_QUAD, 17'h08000, 0, 0, 1, -1, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_QUAD, 17'h08000, 0, 0, 3, -3, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_CUBIC, 17'h05555, 0, 0, 1, -1, -1, 1, 0, 0, 0, 0, 0);
        add_row(KIND_CUBIC, 17'h0AAAB, -1, 1, 2, -2, -3, 3, 4, -4, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vec_tbl[i])
            send_req(vec_tbl[i].r, vec_tbl[i].typed, vec_tbl[i].pt);
        drain_points();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == 600)
                rx_hold = HOLD_CYCLES;
            if (n == 1200)
                drain_points();
            send_req(rand_req(), 1'b0, '0);
        end
        drain_points();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
src/bcp_pkg.sv
src/bezier_curve_point.sv
test/tb_bezier_curve_point.sv
